// ===== src/ahmc_pkg.sv =====
package ahmc_pkg;

    // Media type lengths and the saturation limit of the token length counter.
    localparam logic [4:0] JSON_LEN   = 5'd16;
    localparam logic [4:0] STREAM_LEN = 5'd17;
    localparam logic [4:0] LEN_MAX    = 5'd31;

    // Separator characters.
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SEMI  = 8'h3B;

    // One header character with its framing bits.
    typedef struct packed {
        logic [7:0] char_byte;
        logic       has_byte;
        logic       last_byte;
    } t_in_item;

    // One classification result.
    typedef struct packed {
        logic verdict;
        logic json_seen;
        logic stream_seen;
    } t_out_item;

    // Lower-case folding of ASCII capitals only.
    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    // Characters of "application/json" by position.
    function automatic logic [7:0] json_char(input logic [3:0] idx);
        logic [7:0] r;
        case (idx)
            4'd0:    r = "a";
            4'd1:    r = "p";
            4'd2:    r = "p";
            4'd3:    r = "l";
            4'd4:    r = "i";
            4'd5:    r = "c";
            4'd6:    r = "a";
            4'd7:    r = "t";
            4'd8:    r = "i";
            4'd9:    r = "o";
            4'd10:   r = "n";
            4'd11:   r = "/";
            4'd12:   r = "j";
            4'd13:   r = "s";
            4'd14:   r = "o";
            default: r = "n";
        endcase
        return r;
    endfunction

    // Characters of "text/event-stream" by position.
    function automatic logic [7:0] stream_char(input logic [4:0] idx);
        logic [7:0] r;
        case (idx)
            5'd0:    r = "t";
            5'd1:    r = "e";
            5'd2:    r = "x";
            5'd3:    r = "t";
            5'd4:    r = "/";
            5'd5:    r = "e";
            5'd6:    r = "v";
            5'd7:    r = "e";
            5'd8:    r = "n";
            5'd9:    r = "t";
            5'd10:   r = "-";
            5'd11:   r = "s";
            5'd12:   r = "t";
            5'd13:   r = "r";
            5'd14:   r = "e";
            5'd15:   r = "a";
            default: r = "m";
        endcase
        return r;
    endfunction

endpackage

// ===== src/ahmc_parser.sv =====
module ahmc_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_go,
    input  ahmc_pkg::t_in_item   i_item,
    input  logic                 i_strict,
    output logic                 o_res_valid,
    output ahmc_pkg::t_out_item  o_res
);

    localparam logic [1:0] PH_SKIP   = 2'd0;
    localparam logic [1:0] PH_TOKEN  = 2'd1;
    localparam logic [1:0] PH_PARAMS = 2'd2;

    logic [1:0] r_phase, n_phase;
    logic [4:0] r_len, n_len;
    logic       r_jrun, n_jrun;
    logic       r_srun, n_srun;
    logic       r_jflag, n_jflag;
    logic       r_sflag, n_sflag;

    logic [7:0] lc;
    logic       blank, comma, semi, sep;
    logic [4:0] tb_len;
    logic       tb_jrun, tb_srun;
    logic       j_hit, s_hit;
    logic       fin_j, fin_s;

    // Character classes of the current byte.
    assign lc    = ahmc_pkg::fold_case(i_item.char_byte);
    assign blank = (i_item.char_byte == ahmc_pkg::CH_SPACE) ||
                   (i_item.char_byte == ahmc_pkg::CH_TAB);
    assign comma = (i_item.char_byte == ahmc_pkg::CH_COMMA);
    assign semi  = (i_item.char_byte == ahmc_pkg::CH_SEMI);
    assign sep   = blank || comma || semi;

    // Match step for a token byte; a byte seen while skipping opens a fresh token.
    assign tb_len  = (r_phase == PH_SKIP) ? 5'd0 : r_len;
    assign tb_jrun = (r_phase == PH_SKIP) ? 1'b1 : r_jrun;
    assign tb_srun = (r_phase == PH_SKIP) ? 1'b1 : r_srun;
    assign j_hit   = (tb_len < ahmc_pkg::JSON_LEN) &&
                     (lc == ahmc_pkg::json_char(tb_len[3:0]));
    assign s_hit   = (tb_len < ahmc_pkg::STREAM_LEN) &&
                     (lc == ahmc_pkg::stream_char(tb_len));

    // Next header state and the end-of-header judgement.
    always_comb begin
        n_phase = r_phase;
        n_len   = r_len;
        n_jrun  = r_jrun;
        n_srun  = r_srun;
        n_jflag = r_jflag;
        n_sflag = r_sflag;
        if (i_item.has_byte) begin
            unique case (r_phase)
                PH_SKIP: begin
                    if (semi) begin
                        n_phase = PH_PARAMS;
                    end else if (!(blank || comma)) begin
                        n_phase = PH_TOKEN;
                        n_jrun  = j_hit;
                        n_srun  = s_hit;
                        n_len   = 5'd1;
                    end
                end
                PH_TOKEN: begin
                    if (sep) begin
                        if (r_len == ahmc_pkg::JSON_LEN && r_jrun) begin
                            n_jflag = 1'b1;
                        end
                        if (r_len == ahmc_pkg::STREAM_LEN && r_srun) begin
                            n_sflag = 1'b1;
                        end
                        n_phase = comma ? PH_SKIP : PH_PARAMS;
                    end else begin
                        n_jrun = tb_jrun && j_hit;
                        n_srun = tb_srun && s_hit;
                        if (r_len < ahmc_pkg::LEN_MAX) begin
                            n_len = r_len + 5'd1;
                        end
                    end
                end
                default: begin
                    if (comma) begin
                        n_phase = PH_SKIP;
                    end
                end
            endcase
        end

        // A token still open at the end of the header is judged too.
        fin_j = n_jflag ||
                (n_phase == PH_TOKEN && n_len == ahmc_pkg::JSON_LEN && n_jrun);
        fin_s = n_sflag ||
                (n_phase == PH_TOKEN && n_len == ahmc_pkg::STREAM_LEN && n_srun);

        o_res.json_seen   = fin_j;
        o_res.stream_seen = fin_s;
        o_res.verdict     = i_strict ? !(fin_j && fin_s) : !(fin_j || !fin_s);
        o_res_valid       = i_go && i_item.last_byte;

        if (i_item.last_byte) begin
            n_phase = PH_SKIP;
            n_len   = 5'd0;
            n_jrun  = 1'b1;
            n_srun  = 1'b1;
            n_jflag = 1'b0;
            n_sflag = 1'b0;
        end
    end

    // Header state registers, updated once per processed beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SKIP;
            r_len   <= 5'd0;
            r_jrun  <= 1'b1;
            r_srun  <= 1'b1;
            r_jflag <= 1'b0;
            r_sflag <= 1'b0;
        end else if (i_go) begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_jrun  <= n_jrun;
            r_srun  <= n_srun;
            r_jflag <= n_jflag;
            r_sflag <= n_sflag;
        end
    end

    // A finished header leaves the state clean for the next one.
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_go && i_item.last_byte |=>
            r_phase == PH_SKIP && r_len == 5'd0 && !r_jflag && !r_sflag)
        else $error("header state not cleared after last beat");

    // Inside a token at least one byte has been counted.
    a_token_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_TOKEN |-> r_len != 5'd0)
        else $error("token phase with zero length");

endmodule

// ===== src/accept_header_media_classifier.sv =====
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_ready    i_in_item  (ahmc_pkg::t_in_item)
// output    out        o_out_valid / i_out_ready  o_out_item (ahmc_pkg::t_out_item)
// config    in         i_cfg_we                   i_cfg_wdata (strict mode)
//
// One beat is accepted per cycle unless a last beat waits on a stalled result; a result is
// offered by the result register once its last beat has passed the input register and parser.
// Reset is synchronous and active low, and clears all header state and strict mode.
// A stalled result blocks only a following last beat; other beats keep flowing.
module accept_header_media_classifier (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  ahmc_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output ahmc_pkg::t_out_item  o_out_item,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_wdata
);

    logic                r_strict;
    logic                r_in_valid;
    ahmc_pkg::t_in_item  r_in;
    logic                r_out_valid;
    ahmc_pkg::t_out_item r_out;
    logic                s1_go;
    logic                res_valid;
    ahmc_pkg::t_out_item res;

    // Strict mode register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strict <= 1'b0;
        end else if (i_cfg_we) begin
            r_strict <= i_cfg_wdata;
        end
    end

    // The registered beat moves on unless it would produce a result with nowhere to go.
    assign s1_go      = r_in_valid &&
                        (!r_in.last_byte || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || s1_go;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    ahmc_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (s1_go),
        .i_item      (r_in),
        .i_strict    (r_strict),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // A new result is only ever produced from a processed last beat.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(s1_go && r_in.last_byte))
        else $error("result without a last beat");

    // A result waiting while the consumer stalls is never overwritten.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |-> !res_valid)
        else $error("pending result overwritten");

    // Back-pressure only appears while a beat is held in the input register.
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_in_valid && r_in.last_byte && r_out_valid)
        else $error("input stalled without cause");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import ahmc_pkg::*;

    localparam int unsigned DRAIN_CYCLES   = 4;
    localparam int unsigned WATCHDOG_LIMIT = 500;
    localparam int unsigned PHASE_BEATS    = 270;
    localparam int unsigned PHASE_HEADERS  = 8;

    // Parser phases of the predictor; the unused code behaves as parameter skipping.
    typedef enum logic [1:0] {
        SCAN_SKIP   = 2'd0,
        SCAN_TOKEN  = 2'd1,
        SCAN_PARAMS = 2'd2
    } t_scan;

    // One row of the directed table: an optional mode write, the beat, and a typed result.
    typedef struct packed {
        bit        set_mode;
        bit        mode;
        t_in_item  beat;
        bit        typed;
        t_out_item result;
    } t_plan_row;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_item   = '0;
    logic      i_out_ready = 1'b0;
    logic      i_cfg_we    = 1'b0;
    logic      i_cfg_wdata = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_item;

    // Predictor state.
    string       json_ref    = "application/json";
    string       stream_ref  = "text/event-stream";
    bit          strict_mode = 1'b0;
    t_scan       scan_st     = SCAN_SKIP;
    logic [4:0]  tok_len     = '0;
    bit          json_live   = 1'b1;
    bit          stream_live = 1'b1;
    bit          json_hit    = 1'b0;
    bit          stream_hit  = 1'b0;

    t_out_item   pending_verdicts [$];
    int unsigned beats_sent     = 0;
    int unsigned headers_closed = 0;
    int unsigned fail_count     = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned hold_left      = 0;
    bit          rx_quiet       = 1'b0;

    // Directed beats: separators in every phase, zero and top bytes, empty headers.
    t_plan_row plan [18] = '{
        {1'b1, 1'b0, 8'h00,    1'b0, 1'b1, 1'b1, 3'b000},
        {1'b0, 1'b0, 8'h41,    1'b0, 1'b0, 1'b0, 3'b000},
        {1'b0, 1'b0, 8'h00,    1'b1, 1'b0, 1'b0, 3'b000},
        {1'b0, 1'b0, 8'hFF,    1'b1, 1'b0, 1'b0, 3'b000},
        {1'b0, 1'b0, CH_SPACE, 1'b1, 1'b0, 1'b0, 3'b000},
        {1'b0, 1'b0, CH_SEMI,  1'b1, 1'b0, 1'b0, 3'b000},
        {1'b0, 1'b0, CH_COMMA, 1'b1, 1'b0, 1'b0, 3'b000},
        {1'b0, 1'b0, CH_TAB,   1'b1, 1'b0, 1'b0, 3'b000},
        {1'b0, 1'b0, CH_SEMI,  1'b1, 1'b0, 1'b0, 3'b000},
        {1'b0, 1'b0, CH_COMMA, 1'b1, 1'b0, 1'b0, 3'b000},
        {1'b0, 1'b0, 8'h41,    1'b1, 1'b0, 1'b0, 3'b000},
        {1'b0, 1'b0, 8'h00,    1'b0, 1'b1, 1'b1, 3'b000},
        {1'b0, 1'b0, CH_COMMA, 1'b1, 1'b1, 1'b1, 3'b000},
        {1'b0, 1'b0, CH_SEMI,  1'b1, 1'b1, 1'b1, 3'b000},
        {1'b1, 1'b1, 8'h00,    1'b0, 1'b1, 1'b1, 3'b100},
        {1'b0, 1'b0, 8'h5A,    1'b1, 1'b1, 1'b1, 3'b100},
        {1'b0, 1'b0, 8'h7F,    1'b1, 1'b0, 1'b0, 3'b000},
        {1'b0, 1'b0, 8'h80,    1'b1, 1'b1, 1'b0, 3'b000}
    };

    accept_header_media_classifier dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Clock with an 8 ns period.
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    function automatic int unsigned draw_wait(input bit quiet);
        return quiet ? 0 : $urandom_range(0, 13);
    endfunction

    // A media type is judged when it closes: exact length and every byte matched.
    function automatic void close_type();
        if (tok_len == JSON_LEN && json_live) begin
            json_hit = 1'b1;
        end
        if (tok_len == STREAM_LEN && stream_live) begin
            stream_hit = 1'b1;
        end
    endfunction

    // Folds ASCII capitals and compares against both media types at the current position.
    function automatic void take_char(input logic [7:0] c);
        logic [7:0] lc;
        lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
        if (!(tok_len < JSON_LEN && lc == json_ref[tok_len])) begin
            json_live = 1'b0;
        end
        if (!(tok_len < STREAM_LEN && lc == stream_ref[tok_len])) begin
            stream_live = 1'b0;
        end
        if (tok_len < LEN_MAX) begin
            tok_len++;
        end
    endfunction

    // Advances the header parse by one beat and yields the result at the end of a header.
    task automatic classify_beat(input t_in_item beat, output bit closed, output t_out_item res);
        bit blank;
        bit comma;
        bit semi;
        bit ok;
        closed = 1'b0;
        res    = '0;
        blank  = (beat.char_byte == CH_SPACE || beat.char_byte == CH_TAB);
        comma  = (beat.char_byte == CH_COMMA);
        semi   = (beat.char_byte == CH_SEMI);
        if (beat.has_byte) begin
            case (scan_st)
                SCAN_SKIP: begin
                    if (semi) begin
                        scan_st = SCAN_PARAMS;
                    end else if (!(blank || comma)) begin
                        scan_st     = SCAN_TOKEN;
                        tok_len     = '0;
                        json_live   = 1'b1;
                        stream_live = 1'b1;
                        take_char(beat.char_byte);
                    end
                end
                SCAN_TOKEN: begin
                    if (blank || comma || semi) begin
                        close_type();
                        scan_st = comma ? SCAN_SKIP : SCAN_PARAMS;
                    end else begin
                        take_char(beat.char_byte);
                    end
                end
                default: begin
                    if (comma) begin
                        scan_st = SCAN_SKIP;
                    end
                end
            endcase
        end
        if (beat.last_byte) begin
            if (scan_st == SCAN_TOKEN) begin
                close_type();
            end
            ok = strict_mode ? (json_hit && stream_hit) : (json_hit || !stream_hit);
            res.verdict     = !ok;
            res.json_seen   = json_hit;
            res.stream_seen = stream_hit;
            closed          = 1'b1;
            scan_st         = SCAN_SKIP;
            tok_len         = '0;
            json_live       = 1'b1;
            stream_live     = 1'b1;
            json_hit        = 1'b0;
            stream_hit      = 1'b0;
        end
    endtask

    // Presents one beat after an idle gap, holds it until accepted, then predicts.
    task automatic send_beat(input t_in_item beat, input int unsigned gap, input bit typed,
                             input t_out_item typed_res);
        bit        closed;
        t_out_item predicted;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= beat;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        classify_beat(beat, closed, predicted);
        beats_sent++;
        if (closed) begin
            pending_verdicts.push_back(typed ? typed_res : predicted);
            headers_closed++;
        end
    endtask

    // The mode is only changed once the block has drained.
    task automatic set_strict(input bit mode);
        i_in_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mode;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        strict_mode = mode;
    endtask

    function automatic logic [7:0] sep_byte(input bit with_comma);
        case ($urandom_range(0, with_comma ? 2 : 1))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            default: return CH_COMMA;
        endcase
    endfunction

    // Any byte that does not end a media type.
    function automatic logic [7:0] token_byte();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(0, 255));
        end while (c == CH_SPACE || c == CH_TAB || c == CH_COMMA || c == CH_SEMI);
        return c;
    endfunction

    // Builds one header, mostly well-formed media type lists, and sends it beat by beat.
    task automatic send_header();
        logic [7:0]  hdr [$];
        logic [7:0]  ch;
        logic [7:0]  c;
        string       ref_txt;
        int unsigned n_types;
        int unsigned pick;
        int unsigned cut;
        int unsigned variant;
        int unsigned term;
        bit          quiet;
        bit          tail_beat;
        t_in_item    beat;
        quiet = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 24)) hdr.push_back(8'($urandom_range(0, 255)));
        end else begin
            n_types = $urandom_range(0, 3);
            for (int k = 0; k < n_types; k++) begin
                repeat ($urandom_range(0, 2)) hdr.push_back(sep_byte(1'b1));
                pick = $urandom_range(0, 9);
                if (pick <= 6) begin
                    // Either media type in random case; a near miss drops or replaces one position or appends a byte.
                    ref_txt = (pick % 2 == 0) ? json_ref : stream_ref;
                    cut     = $urandom_range(0, ref_txt.len() - 1);
                    variant = $urandom_range(0, 2);
                    for (int i = 0; i < ref_txt.len(); i++) begin
                        ch = ref_txt[i];
                        if (ch >= "a" && ch <= "z" && $urandom_range(0, 1)) begin
                            ch = ch - 8'd32;
                        end
                        if (pick == 6 && i == cut && variant == 0) begin
                            continue;
                        end
                        if (pick == 6 && i == cut && variant == 1) begin
                            ch = token_byte();
                        end
                        hdr.push_back(ch);
                    end
                    if (pick == 6 && variant == 2) begin
                        hdr.push_back(token_byte());
                    end
                end else if (pick == 7) begin
                    repeat ($urandom_range(14, 40)) hdr.push_back(token_byte());
                end else if (pick == 8) begin
                    repeat ($urandom_range(1, 6)) hdr.push_back(token_byte());
                end
                // End of the media type, then perhaps parameters up to the next comma.
                term = $urandom_range(0, 3);
                case (term)
                    1:       hdr.push_back(CH_SEMI);
                    2:       hdr.push_back(sep_byte(1'b0));
                    3:       hdr.push_back(CH_COMMA);
                    default: ;
                endcase
                if (term == 1 || term == 2) begin
                    repeat ($urandom_range(0, 4)) begin
                        do begin
                            c = 8'($urandom_range(0, 255));
                        end while (c == CH_COMMA);
                        hdr.push_back(c);
                    end
                end
                if (k < n_types - 1 && term != 3) begin
                    hdr.push_back(CH_COMMA);
                end
            end
        end
        tail_beat = (hdr.size() == 0) || ($urandom_range(0, 2) == 0);
        foreach (hdr[i]) begin
            if ($urandom_range(0, 19) == 0) begin
                beat = {8'($urandom_range(0, 255)), 1'b0, 1'b0};
                send_beat(beat, draw_wait(quiet), 1'b0, '0);
            end
            beat = {hdr[i], 1'b1, !tail_beat && (i == hdr.size() - 1)};
            send_beat(beat, draw_wait(quiet), 1'b0, '0);
        end
        if (tail_beat) begin
            beat = {8'($urandom_range(0, 255)), 1'b0, 1'b1};
            send_beat(beat, draw_wait(quiet), 1'b0, '0);
        end
    endtask

    // Result side: random stalls per beat, with quiet stretches of none.
    always @(posedge i_clk) begin : result_side
        int unsigned stall;
        if ($urandom_range(0, 99) == 0) begin
            rx_quiet <= !rx_quiet;
        end
        if (o_out_valid && i_out_ready) begin
            stall = draw_wait(rx_quiet);
            hold_left   <= stall;
            i_out_ready <= (stall == 0);
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= (hold_left == 1);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    function automatic void note_mismatch(input string field, input logic want, input logic got);
        $display("%0t: %s expected %b, got %b", $time, field, want, got);
        fail_count++;
    endfunction

    // Each result beat is compared with the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_verdicts.size() == 0) begin
                $display("%0t: result expected none, got %b", $time, o_out_item);
                fail_count++;
            end else begin
                want = pending_verdicts.pop_front();
                if (o_out_item.verdict !== want.verdict) begin
                    note_mismatch("verdict", want.verdict, o_out_item.verdict);
                end
                if (o_out_item.json_seen !== want.json_seen) begin
                    note_mismatch("json_seen", want.json_seen, o_out_item.json_seen);
                end
                if (o_out_item.stream_seen !== want.stream_seen) begin
                    note_mismatch("stream_seen", want.stream_seen, o_out_item.stream_seen);
                end
            end
        end
    end

    // Ends the run if no beat moves on either channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("accept_header_media_classifier: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Reset, directed table, then random headers under alternating modes.
    initial begin
        int unsigned start_beats;
        int unsigned start_headers;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (plan[r]) begin
            if (plan[r].set_mode) begin
                set_strict(plan[r].mode);
            end
            send_beat(plan[r].beat, draw_wait(1'b0), plan[r].typed, plan[r].result);
        end
        for (int ph = 0; ph < 4; ph++) begin
            set_strict(ph % 2 == 1);
            start_beats   = beats_sent;
            start_headers = headers_closed;
            while (beats_sent - start_beats < PHASE_BEATS
                   || headers_closed - start_headers < PHASE_HEADERS) begin
                send_header();
            end
        end
        i_in_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("accept_header_media_classifier: match");
        end else begin
            $display("accept_header_media_classifier: mismatch");
        end
        $finish;
    end

endmodule
